// ===== rtl/core/tsr_pkg.sv =====
// Shared types for the triangle span rasterizer.
package tsr_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/core/triangle_span_rasterizer.sv =====
// Top level of the triangle span rasterizer: vertex sort, edge walk and span output.
//
//  Channel | Direction | Handshake          | Payload
//  request | in        | i_valid / o_ready  | i_op, i_ax..i_cy, i_fill_color
//  span    | out       | o_valid / i_ready  | o_row, o_x_left, o_x_right, o_draw, o_last, o_color
//
// A row step puts its span into an output register.
// A load, and a step that crosses the middle vertex, run two bit-serial dividers side by
// side, and no request is taken until they are done.
// A load whose top and middle rows match skips the first divisions and runs only the second.
// Reset is synchronous and active low and leaves the block idle with no triangle.
// Requests stall while the span register is full and not being taken.
module triangle_span_rasterizer #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_ax,
    input  logic [COORD_BITS-1:0] i_ay,
    input  logic [COORD_BITS-1:0] i_bx,
    input  logic [COORD_BITS-1:0] i_by,
    input  logic [COORD_BITS-1:0] i_cx,
    input  logic [COORD_BITS-1:0] i_cy,
    input  logic [7:0]            i_fill_color,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_row,
    output logic [COORD_BITS-1:0] o_x_left,
    output logic [COORD_BITS-1:0] o_x_right,
    output logic                  o_draw,
    output logic                  o_last,
    output logic [7:0]            o_color
);
    localparam int C = COORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int A = C + F + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LDIV = 2'd1;
    localparam logic [1:0] ST_MDIV = 2'd2;

    localparam logic OP_LOAD = 1'b0;

    logic [1:0]            r_state, n_state;
    logic [C-1:0]          r_vtx [6];
    logic [C-1:0]          n_vtx [6];
    logic signed [A-1:0]   r_lacc, n_lacc, r_racc, n_racc;
    logic signed [A-1:0]   r_lslp, n_lslp, r_rslp, n_rslp;
    logic [C-1:0]          r_row, n_row, r_end, n_end;
    logic                  r_first, n_first, r_second, n_second, r_midleft, n_midleft;
    logic [7:0]            r_color, n_color;
    logic                  r_ovalid, n_ovalid;
    logic [C-1:0]          r_orow, n_orow, r_oxl, n_oxl, r_oxr, n_oxr;
    logic                  r_odraw, n_odraw, r_olast, n_olast;
    logic [7:0]            r_ocolor, n_ocolor;

    logic                  in_acc;
    logic                  ord_ok, ord_ml;
    logic [C-1:0]          ov [6];
    logic signed [A-1:0]   step_l, step_r;
    logic [C-1:0]          step_row;
    logic [C-1:0]          bs_xi, bs_xm, bs_ym, bs_xf, bs_yf;
    logic                  bs_ml;
    logic                  div_start;
    logic signed [C:0]     dl_dx, dr_dx;
    logic [C-1:0]          dl_dy, dr_dy;
    tsr_pkg::t_div_stat    st_l, st_r;
    logic signed [C+F:0]   q_l, q_r;

    function automatic logic [C-1:0] acc_int(input logic signed [A-1:0] acc);
        acc_int = acc[A-1] ? '0 : acc[F+C-1:F];
    endfunction

    function automatic logic signed [A-1:0] to_fx(input logic [C-1:0] x);
        to_fx = $signed({2'b00, x, {F{1'b0}}});
    endfunction

    function automatic logic signed [C:0] sub_x(input logic [C-1:0] x1, input logic [C-1:0] x0);
        sub_x = $signed({1'b0, x1}) - $signed({1'b0, x0});
    endfunction

    assign o_ready = (r_state == ST_IDLE) && (!r_ovalid || i_ready);
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        ord_ok = 1'b1;
        ord_ml = 1'b0;
        ov[0] = i_ax; ov[1] = i_ay; ov[2] = i_bx; ov[3] = i_by; ov[4] = i_cx; ov[5] = i_cy;
        if (i_ay < i_by && i_ay < i_cy && i_by >= i_cy) begin
            ov[0] = i_ax; ov[1] = i_ay; ov[2] = i_cx; ov[3] = i_cy; ov[4] = i_bx; ov[5] = i_by;
        end else if (i_ay < i_by && i_ay >= i_cy && i_by > i_cy) begin
            ov[0] = i_cx; ov[1] = i_cy; ov[2] = i_ax; ov[3] = i_ay; ov[4] = i_bx; ov[5] = i_by;
            ord_ml = 1'b1;
        end else if (i_ay >= i_by && i_ay > i_cy && i_by > i_cy) begin
            ov[0] = i_cx; ov[1] = i_cy; ov[2] = i_bx; ov[3] = i_by; ov[4] = i_ax; ov[5] = i_ay;
        end else if (i_ay > i_by && i_by <= i_cy && i_ay > i_cy) begin
            ov[0] = i_bx; ov[1] = i_by; ov[2] = i_cx; ov[3] = i_cy; ov[4] = i_ax; ov[5] = i_ay;
            ord_ml = 1'b1;
        end else if (i_ay > i_by && i_by < i_cy && i_ay <= i_cy) begin
            ov[0] = i_bx; ov[1] = i_by; ov[2] = i_ax; ov[3] = i_ay; ov[4] = i_cx; ov[5] = i_cy;
        end else if (i_ay <= i_by && i_by < i_cy && i_ay < i_cy) begin
            ov[0] = i_ax; ov[1] = i_ay; ov[2] = i_bx; ov[3] = i_by; ov[4] = i_cx; ov[5] = i_cy;
            ord_ml = 1'b1;
        end else begin
            ord_ok = 1'b0;
        end
    end

    always_comb begin
        step_l   = r_lacc + r_lslp;
        step_r   = r_racc + r_rslp;
        step_row = r_row + 1'b1;
    end

    always_comb begin
        n_state   = r_state;
        n_vtx     = r_vtx;
        n_lacc    = r_lacc;
        n_racc    = r_racc;
        n_lslp    = r_lslp;
        n_rslp    = r_rslp;
        n_row     = r_row;
        n_end     = r_end;
        n_first   = r_first;
        n_second  = r_second;
        n_midleft = r_midleft;
        n_color   = r_color;
        n_ovalid  = r_ovalid && !i_ready;
        n_orow    = r_orow;
        n_oxl     = r_oxl;
        n_oxr     = r_oxr;
        n_odraw   = r_odraw;
        n_olast   = r_olast;
        n_ocolor  = r_ocolor;
        div_start = 1'b0;
        bs_ml = r_midleft;
        bs_xm = r_vtx[2];
        bs_ym = r_vtx[3];
        bs_xf = r_vtx[4];
        bs_yf = r_vtx[5];
        bs_xi = acc_int(r_midleft ? step_r : step_l);
        dl_dx = '0;
        dl_dy = '0;
        dr_dx = '0;
        dr_dy = '0;

        if (in_acc && i_op == OP_LOAD) begin
            bs_ml = ord_ml;
            bs_xm = ov[2];
            bs_ym = ov[3];
            bs_xf = ov[4];
            bs_yf = ov[5];
            bs_xi = ov[0];
        end

        if (in_acc && i_op == OP_LOAD) begin
            n_color = i_fill_color;
            if (!ord_ok) begin
                n_first  = 1'b0;
                n_second = 1'b0;
            end else begin
                n_vtx     = ov;
                n_midleft = ord_ml;
                n_lacc    = to_fx(ov[0]);
                n_racc    = to_fx(ov[0]);
                n_row     = ov[1];
                n_end     = ov[3];
                n_first   = 1'b1;
                n_second  = 1'b0;
                div_start = 1'b1;
                if (ov[3] != ov[1]) begin
                    n_state = ST_LDIV;
                    if (ord_ml) begin
                        dl_dx = sub_x(ov[2], ov[0]);
                        dl_dy = ov[3] - ov[1];
                        dr_dx = sub_x(ov[4], ov[0]);
                        dr_dy = ov[5] - ov[1];
                    end else begin
                        dl_dx = sub_x(ov[4], ov[0]);
                        dl_dy = ov[5] - ov[1];
                        dr_dx = sub_x(ov[2], ov[0]);
                        dr_dy = ov[3] - ov[1];
                    end
                end
            end
        end else if (in_acc && (r_first || r_second)) begin
            n_ovalid = 1'b1;
            n_orow   = step_row;
            n_oxl    = acc_int(step_l);
            n_oxr    = acc_int(step_r);
            n_odraw  = (step_l < step_r);
            n_olast  = 1'b0;
            n_ocolor = r_color;
            n_row    = step_row;
            n_lacc   = step_l;
            n_racc   = step_r;
            if (step_row == r_end) begin
                if (r_first && r_vtx[3] != r_vtx[5]) begin
                    div_start = 1'b1;
                end else begin
                    n_first  = 1'b0;
                    n_second = 1'b0;
                    n_olast  = 1'b1;
                end
            end
        end

        if (div_start && n_state != ST_LDIV) begin
            n_state  = ST_MDIV;
            n_first  = 1'b0;
            n_second = 1'b1;
            n_row    = bs_ym;
            n_end    = bs_yf;
            dl_dy    = bs_yf - bs_ym;
            dr_dy    = bs_yf - bs_ym;
            if (bs_ml) begin
                n_racc = to_fx(bs_xi);
                n_lacc = to_fx(bs_xm);
                dr_dx  = sub_x(bs_xf, bs_xi);
                dl_dx  = sub_x(bs_xf, bs_xm);
            end else begin
                n_lacc = to_fx(bs_xi);
                n_racc = to_fx(bs_xm);
                dl_dx  = sub_x(bs_xf, bs_xi);
                dr_dx  = sub_x(bs_xf, bs_xm);
            end
        end

        if ((r_state == ST_LDIV || r_state == ST_MDIV) && st_l.done) begin
            n_lslp  = {q_l[C+F], q_l};
            n_rslp  = {q_r[C+F], q_r};
            n_state = ST_IDLE;
        end
    end

    tsr_div #(.COORD_BITS(C), .FRAC_BITS(F)) u_div_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dx    (dl_dx),
        .i_dy    (dl_dy),
        .o_stat  (st_l),
        .o_quot  (q_l)
    );

    tsr_div #(.COORD_BITS(C), .FRAC_BITS(F)) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dx    (dr_dx),
        .i_dy    (dr_dy),
        .o_stat  (st_r),
        .o_quot  (q_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vtx     <= '{default: '0};
            r_lacc    <= '0;
            r_racc    <= '0;
            r_lslp    <= '0;
            r_rslp    <= '0;
            r_row     <= '0;
            r_end     <= '0;
            r_first   <= 1'b0;
            r_second  <= 1'b0;
            r_midleft <= 1'b0;
            r_color   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vtx     <= n_vtx;
            r_lacc    <= n_lacc;
            r_racc    <= n_racc;
            r_lslp    <= n_lslp;
            r_rslp    <= n_rslp;
            r_row     <= n_row;
            r_end     <= n_end;
            r_first   <= n_first;
            r_second  <= n_second;
            r_midleft <= n_midleft;
            r_color   <= n_color;
            r_ovalid  <= n_ovalid;
        end
        r_orow   <= n_orow;
        r_oxl    <= n_oxl;
        r_oxr    <= n_oxr;
        r_odraw  <= n_odraw;
        r_olast  <= n_olast;
        r_ocolor <= n_ocolor;
    end

    assign o_valid   = r_ovalid;
    assign o_row     = r_orow;
    assign o_x_left  = r_oxl;
    assign o_x_right = r_oxr;
    assign o_draw    = r_odraw;
    assign o_last    = r_olast;
    assign o_color   = r_ocolor;

`ifndef ASSERT_OFF
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_l.busy == st_r.busy && st_l.done == st_r.done)
        else $error("edge dividers out of step");

    a_div_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_l.busy |-> (r_state == ST_LDIV || r_state == ST_MDIV))
        else $error("divider running outside a division state");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (!r_first && !r_second))
        else $error("triangle still active after its final span");

    a_no_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("request taken while slopes are being divided");
`endif
endmodule

// ===== rtl/core/tsr_div.sv =====
// Bit-serial signed divider for edge slopes: (dx << FRAC_BITS) / dy, truncated toward zero.
module tsr_div #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [COORD_BITS:0]             i_dx,
    input  logic        [COORD_BITS-1:0]           i_dy,
    output tsr_pkg::t_div_stat                     o_stat,
    output logic signed [COORD_BITS+FRAC_BITS:0]   o_quot
);
    localparam int N  = COORD_BITS + FRAC_BITS;
    localparam int CW = $clog2(N + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [N-1:0]          r_sh, n_sh;
    logic [COORD_BITS-1:0] r_rem, n_rem;
    logic [COORD_BITS-1:0] r_den, n_den;
    logic                  r_neg, n_neg;

    logic [COORD_BITS:0]   mag;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;
    logic [N-1:0]          q;

    always_comb begin
        mag   = i_dx[COORD_BITS] ? (~i_dx + 1'b1) : i_dx;
        trial = {r_rem, r_sh[N-1]};
        ge    = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(N);
            n_sh   = {mag[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
            n_rem  = '0;
            n_den  = i_dy;
            n_neg  = i_dx[COORD_BITS];
        end else if (r_busy) begin
            n_sh  = {r_sh[N-2:0], ge};
            n_rem = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign q = (r_den == '0) ? '0 : r_sh;
    assign o_quot = r_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

// ===== tb/triangle_span_rasterizer_tb.sv =====
// Self-checking testbench for the triangle span rasterizer: directed table, then random triangles.
module triangle_span_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 8;
    localparam longint ONE_FX = longint'(1) << FRAC_BITS;
    localparam longint CMASK  = (longint'(1) << COORD_BITS) - 1;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_ITEMS    = 1500;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [2:0] PH_IDLE    = 3'b000;
    localparam logic [2:0] PH_FIRST   = 3'b001;
    localparam logic [2:0] PH_SECOND  = 3'b010;
    localparam logic [2:0] PH_MIDLEFT = 3'b100;

    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
        logic [7:0]            color;
    } t_req;

    typedef struct packed {
        logic [COORD_BITS-1:0] row, x_left, x_right;
        logic                  draw, last;
        logic [7:0]            color;
    } t_span;

    typedef struct packed {
        t_req  req;
        logic  typed;
        t_span span;
    } t_table_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_op = OP_STEP;
    logic [COORD_BITS-1:0] i_ax = '0, i_ay = '0, i_bx = '0, i_by = '0, i_cx = '0, i_cy = '0;
    logic [7:0]            i_fill_color = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [COORD_BITS-1:0] o_row, o_x_left, o_x_right;
    logic                  o_draw, o_last;
    logic [7:0]            o_color;

    triangle_span_rasterizer #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by(i_by),
        .i_cx(i_cx), .i_cy(i_cy), .i_fill_color(i_fill_color),
        .o_valid(o_valid), .i_ready(i_ready), .o_row(o_row), .o_x_left(o_x_left),
        .o_x_right(o_x_right), .o_draw(o_draw), .o_last(o_last), .o_color(o_color)
    );

    always #5 i_clk = ~i_clk;

    // Edge walker state mirrored from the block.
    longint     vtx[6];
    longint     left_acc, right_acc, left_slope, right_slope;
    longint     cur_row, end_row;
    logic [2:0] phase;
    logic [7:0] held_color;

    t_span pending_spans[$];
    int    n_errors = 0;
    int    n_spans = 0;
    int    n_items = 0;

    function automatic longint edge_slope(longint x0, longint y0, longint x1, longint y1);
        longint dy;
        dy = y1 - y0;
        if (dy <= 0) return 0;
        return ((x1 - x0) * ONE_FX) / dy;
    endfunction

    function automatic longint acc_col(longint acc);
        if (acc < 0) return 0;
        return (acc >>> FRAC_BITS) & CMASK;
    endfunction

    function automatic t_req rand_req();
        logic [95:0] rnd;
        rnd = {$urandom, $urandom, $urandom};
        return rnd[$bits(t_req)-1:0];
    endfunction

    task automatic enter_second_part();
        longint xi;
        if (phase & PH_MIDLEFT) begin
            xi = acc_col(right_acc);
            right_acc = xi * ONE_FX;
            right_slope = edge_slope(xi, vtx[3], vtx[4], vtx[5]);
            left_acc = vtx[2] * ONE_FX;
            left_slope = edge_slope(vtx[2], vtx[3], vtx[4], vtx[5]);
            phase = PH_SECOND | PH_MIDLEFT;
        end else begin
            xi = acc_col(left_acc);
            left_acc = xi * ONE_FX;
            left_slope = edge_slope(xi, vtx[3], vtx[4], vtx[5]);
            right_acc = vtx[2] * ONE_FX;
            right_slope = edge_slope(vtx[2], vtx[3], vtx[4], vtx[5]);
            phase = PH_SECOND;
        end
        cur_row = vtx[3];
        end_row = vtx[5];
    endtask

    task automatic load_triangle(t_req r);
        longint xa, ya, xb, yb, xc, yc;
        longint v[6];
        logic   midleft;
        xa = longint'(r.ax); ya = longint'(r.ay); xb = longint'(r.bx);
        yb = longint'(r.by); xc = longint'(r.cx); yc = longint'(r.cy);
        held_color = r.color;
        if (ya < yb && ya < yc && yb >= yc) begin
            v = '{xa, ya, xc, yc, xb, yb}; midleft = 1'b0;
        end else if (ya < yb && ya >= yc && yb > yc) begin
            v = '{xc, yc, xa, ya, xb, yb}; midleft = 1'b1;
        end else if (ya >= yb && ya > yc && yb > yc) begin
            v = '{xc, yc, xb, yb, xa, ya}; midleft = 1'b0;
        end else if (ya > yb && yb <= yc && ya > yc) begin
            v = '{xb, yb, xc, yc, xa, ya}; midleft = 1'b1;
        end else if (ya > yb && yb < yc && ya <= yc) begin
            v = '{xb, yb, xa, ya, xc, yc}; midleft = 1'b0;
        end else if (ya <= yb && yb < yc && ya < yc) begin
            v = '{xa, ya, xb, yb, xc, yc}; midleft = 1'b1;
        end else begin
            phase = PH_IDLE;
            return;
        end
        vtx = v;
        left_acc = v[0] * ONE_FX;
        right_acc = left_acc;
        if (midleft) begin
            left_slope = edge_slope(v[0], v[1], v[2], v[3]);
            right_slope = edge_slope(v[0], v[1], v[4], v[5]);
        end else begin
            left_slope = edge_slope(v[0], v[1], v[4], v[5]);
            right_slope = edge_slope(v[0], v[1], v[2], v[3]);
        end
        cur_row = v[1];
        end_row = v[3];
        phase = PH_FIRST | (midleft ? PH_MIDLEFT : PH_IDLE);
        if (v[3] == v[1]) enter_second_part();
    endtask

    task automatic predict_span(t_req r, output logic has_span, output t_span s);
        longint row;
        longint xl, xr;
        has_span = 1'b0;
        s = '0;
        if (r.op == OP_LOAD) begin
            load_triangle(r);
            return;
        end
        if (phase == PH_IDLE) return;
        row = (cur_row + 1) & CMASK;
        left_acc += left_slope;
        right_acc += right_slope;
        xl = acc_col(left_acc);
        xr = acc_col(right_acc);
        has_span = 1'b1;
        s.row = row[COORD_BITS-1:0];
        s.x_left = xl[COORD_BITS-1:0];
        s.x_right = xr[COORD_BITS-1:0];
        s.draw = left_acc < right_acc;
        s.color = held_color;
        s.last = 1'b0;
        cur_row = row;
        if (row == end_row) begin
            if ((phase & PH_FIRST) && vtx[3] != vtx[5]) begin
                enter_second_part();
            end else begin
                phase = PH_IDLE;
                s.last = 1'b1;
            end
        end
    endtask

    function automatic t_req mk_req(logic op, int ax, int ay, int bx, int by, int cx, int cy,
                                    int color);
        t_req r;
        r.op = op;
        r.ax = COORD_BITS'(ax); r.ay = COORD_BITS'(ay);
        r.bx = COORD_BITS'(bx); r.by = COORD_BITS'(by);
        r.cx = COORD_BITS'(cx); r.cy = COORD_BITS'(cy);
        r.color = 8'(color);
        return r;
    endfunction

    function automatic t_span mk_span(int row, int xl, int xr, logic draw, logic last,
                                      int color);
        t_span s;
        s.row = COORD_BITS'(row); s.x_left = COORD_BITS'(xl); s.x_right = COORD_BITS'(xr);
        s.draw = draw; s.last = last; s.color = 8'(color);
        return s;
    endfunction

    // Drives one request after a random leading gap, possibly none, waits for acceptance, then predicts its span.
    task automatic send_request(t_req r, logic typed, t_span typed_span);
        logic  has_span;
        t_span s;
        int    gap;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= r.op;
        i_ax <= r.ax; i_ay <= r.ay; i_bx <= r.bx; i_by <= r.by; i_cx <= r.cx; i_cy <= r.cy;
        i_fill_color <= r.color;
        do @(posedge i_clk); while (!o_ready);
        predict_span(r, has_span, s);
        if (typed) s = typed_span;
        if (has_span || typed) pending_spans.push_back(s);
        if (r.op == OP_LOAD || has_span) n_items++;
    endtask

    task automatic send_triangle(int h1, int h2, int extra);
        int    ys[3];
        int    xs[3];
        int    top, k, j, t, n_steps;
        t_req  r;
        top = $urandom_range(0, 1023 - h1 - h2);
        ys = '{top, top + h1, top + h1 + h2};
        for (k = 0; k < 3; k++) xs[k] = $urandom_range(0, 1023);
        for (k = 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = ys[k]; ys[k] = ys[j]; ys[j] = t;
        end
        r = mk_req(OP_LOAD, xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom_range(0, 255));
        send_request(r, 1'b0, '0);
        n_steps = h1 + h2 + extra;
        if ($urandom_range(0, 6) == 0) n_steps = $urandom_range(0, n_steps);
        for (k = 0; k < n_steps; k++) begin
            r.op = OP_STEP;
            if ($urandom_range(0, 3) == 0) begin
                r = rand_req();
                r.op = OP_STEP;
            end
            send_request(r, 1'b0, '0);
        end
    endtask

    t_table_row directed[$];

    initial begin
        int    k;
        t_req  r;
        directed.push_back('{mk_req(OP_STEP, 1023, 1023, 1023, 1023, 1023, 1023, 255), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 100, 0, 100, 2, 104, 2, 8'hAA), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 1,
                             mk_span(1, 100, 102, 1, 0, 8'hAA)});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 1,
                             mk_span(2, 100, 104, 1, 1, 8'hAA)});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 0, 5, 1023, 5, 500, 5, 0), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 0, 0, 1023, 1023, 1023, 0, 255), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 40, 10, 90, 30, 300, 20, 1), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 40, 20, 90, 30, 300, 10, 2), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 40, 30, 90, 20, 300, 10, 3), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 40, 30, 90, 10, 300, 20, 4), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 40, 20, 90, 10, 300, 30, 5), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_req(OP_LOAD, 40, 10, 90, 20, 300, 30, 6), 0, '0});
        directed.push_back('{mk_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0), 0, '0});

        vtx = '{0, 0, 0, 0, 0, 0};
        left_acc = 0; right_acc = 0; left_slope = 0; right_slope = 0;
        cur_row = 0; end_row = 0; phase = PH_IDLE; held_color = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_request(directed[k].req, directed[k].typed,
                                           directed[k].span);

        k = 0;
        while (n_items < N_ITEMS) begin
            if (k == 10) begin
                send_triangle($urandom_range(300, 700), 0, 0);
            end else if (k == 11) begin
                send_triangle(0, 0, 0);
            end else if ($urandom_range(0, 9) == 0) begin
                r = rand_req();
                send_request(r, 1'b0, '0);
            end else begin
                send_triangle($urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 12),
                              $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 12),
                              $urandom_range(0, 2));
            end
            k++;
        end
        i_valid <= 1'b0;

        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[triangle_span_rasterizer] OK");
        end else begin
            $display("[triangle_span_rasterizer] ERROR");
        end
        $finish;
    end

    // Span receiver: checks every accepted span and throttles i_ready.
    initial begin
        t_span want;
        int    stall;
        int    thr;
        int    cyc;
        logic  held;
        stall = 0;
        thr = 100;
        cyc = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (i_rst_n && o_valid && i_ready) begin
                n_spans++;
                if (pending_spans.size() == 0) begin
                    $error("unexpected span: row %0d", o_row);
                    n_errors++;
                end else begin
                    want = pending_spans.pop_front();
                    if (o_row !== want.row) begin
                        $error("row: expected %0d, got %0d", want.row, o_row);
                        n_errors++;
                    end
                    if (o_x_left !== want.x_left) begin
                        $error("x_left: expected %0d, got %0d", want.x_left, o_x_left);
                        n_errors++;
                    end
                    if (o_x_right !== want.x_right) begin
                        $error("x_right: expected %0d, got %0d", want.x_right, o_x_right);
                        n_errors++;
                    end
                    if (o_draw !== want.draw) begin
                        $error("draw: expected %0d, got %0d", want.draw, o_draw);
                        n_errors++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        n_errors++;
                    end
                    if (o_color !== want.color) begin
                        $error("color: expected %0d, got %0d", want.color, o_color);
                        n_errors++;
                    end
                end
            end
            if (cyc % 300 == 0) thr = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(30, 90);
            if (n_spans >= 150 && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 2) begin
                stall = $urandom_range(15, 60);
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) < thr);
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[triangle_span_rasterizer] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
rtl/core/tsr_pkg.sv
rtl/core/tsr_div.sv
rtl/core/triangle_span_rasterizer.sv
tb/triangle_span_rasterizer_tb.sv
